>>> hw/rtl/qrs_pkg.sv
// Shared types, codes and saturation helper for the quadratic root solver.
// No dependencies.
`timescale 1ns / 1ps

package qrs_pkg;

  typedef enum logic [1:0] {
    CMD_SOLVE = 2'd0,
    CMD_EVAL  = 2'd1,
    CMD_MEET  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_AZERO = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  localparam logic [1:0] CNT_CPLX   = 2'd0;
  localparam logic [1:0] CNT_DOUBLE = 2'd1;
  localparam logic [1:0] CNT_TWO    = 2'd2;

  typedef struct packed {
    logic        hit;
    logic [31:0] q;
  } sat_t;

  // results of the evaluate and intersect paths riding along the solve pipe
  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] val;
    logic        meets;
    logic        esat;
    logic        azero;
  } side_t;

  function automatic sat_t sat32(input logic signed [67:0] v);
    sat_t r;
    r.hit = 1'b0;
    r.q   = v[31:0];
    if (v > 68'sh7FFF_FFFF) begin
      r.hit = 1'b1;
      r.q   = 32'h7FFF_FFFF;
    end else if (v < -68'sh8000_0000) begin
      r.hit = 1'b1;
      r.q   = 32'h8000_0000;
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/quadratic_root_solver_unit.sv
// Quadratic solver / evaluator / intersection test, fully pipelined top level.
// Uses qrs_pkg (codes, side-band struct, saturation helper).
// Throughput: one request per cycle unless a stalled valid output holds the pipe; the one-bit-per-stage divider
// (32 + FRAC_BITS stages) and the one-bit-per-stage square root (32 stages) are fully pipelined.
// Reset (rst, synchronous) clears all stage valid bits; data registers keep.
`timescale 1ns / 1ps

module quadratic_root_solver_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         command,
  input  logic signed [31:0] coef_a,
  input  logic signed [31:0] coef_b,
  input  logic signed [31:0] coef_c,
  input  logic signed [31:0] other_a,
  input  logic signed [31:0] other_b,
  input  logic signed [31:0] other_c,
  input  logic signed [31:0] point_x,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] first_real,
  output logic signed [31:0] first_imag,
  output logic signed [31:0] second_real,
  output logic signed [31:0] second_imag,
  output logic [1:0]         real_root_count,
  output logic signed [31:0] poly_value,
  output logic               meets,
  output logic [1:0]         status
);

  localparam int NW = 32 + FRAC_BITS;

  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // stage 0: input registers
  logic                v0;
  qrs_pkg::cmd_t       cmd0;
  logic signed [31:0]  a0, b0, c0, oa0, ob0, oc0, x0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd0 <= qrs_pkg::cmd_t'(command);
      a0   <= coef_a;
      b0   <= coef_b;
      c0   <= coef_c;
      oa0  <= other_a;
      ob0  <= other_b;
      oc0  <= other_c;
      x0   <= point_x;
    end
  end

  // stage 1: a*x, coefficient differences
  logic                v1;
  qrs_pkg::cmd_t       cmd1;
  logic signed [31:0]  a1, b1, c1, x1;
  logic signed [63:0]  m1;
  logic signed [32:0]  ka1, kb1, kc1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd1 <= cmd0;
      a1   <= a0;
      b1   <= b0;
      c1   <= c0;
      x1   <= x0;
      m1   <= 64'(a0) * 64'(x0);
      ka1  <= 33'(a0) - 33'(oa0);
      kb1  <= 33'(b0) - 33'(ob0);
      kc1  <= 33'(c0) - 33'(oc0);
    end
  end

  // stage 2: Horner first step, intersect products
  logic                v2;
  qrs_pkg::cmd_t       cmd2;
  logic signed [31:0]  a2, b2, c2, x2, t2;
  logic                esat2;
  logic [65:0]         kb2, kac2;
  logic                kaz2, kbz2, kcz2, ksd2;
  logic [32:0]         mka, mkb, mkc;
  logic signed [67:0]  e1;
  qrs_pkg::sat_t       ts;

  always_comb begin
    mka = ka1[32] ? 33'(-ka1) : 33'(ka1);
    mkb = kb1[32] ? 33'(-kb1) : 33'(kb1);
    mkc = kc1[32] ? 33'(-kc1) : 33'(kc1);
    e1  = 68'(m1 >>> FRAC_BITS) + 68'(b1);
    ts  = qrs_pkg::sat32(e1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd2  <= cmd1;
      a2    <= a1;
      b2    <= b1;
      c2    <= c1;
      x2    <= x1;
      t2    <= ts.q;
      esat2 <= ts.hit;
      kb2   <= 66'(mkb) * 66'(mkb);
      kac2  <= 66'(mka) * 66'(mkc);
      kaz2  <= (ka1 == '0);
      kbz2  <= (kb1 == '0);
      kcz2  <= (kc1 == '0);
      ksd2  <= ka1[32] != kc1[32];
    end
  end

  // stage 3: t*x, intersect compare
  logic                v3;
  qrs_pkg::cmd_t       cmd3;
  logic signed [31:0]  a3, b3, c3;
  logic signed [63:0]  m3;
  logic                esat3, meets3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd3  <= cmd2;
      a3    <= a2;
      b3    <= b2;
      c3    <= c2;
      m3    <= 64'(t2) * 64'(x2);
      esat3 <= esat2;
      if (kaz2) begin
        meets3 <= !kbz2 || kcz2;
      end else if (ksd2 || kcz2) begin
        meets3 <= 1'b1;
      end else begin
        meets3 <= {2'b00, kb2} >= {kac2, 2'b00};
      end
    end
  end

  // stage 4 (divider entry): Horner second step, divider setup
  logic                dv_v   [0:NW];
  qrs_pkg::side_t      dv_sd  [0:NW];
  logic [31:0]         dv_den [0:NW];
  logic [NW-1:0]       dv_nb  [0:NW];
  logic [NW-1:0]       dv_nc  [0:NW];
  logic [31:0]         dv_rb  [0:NW];
  logic [31:0]         dv_rc  [0:NW];
  logic                dv_sp  [0:NW];
  logic                dv_sq  [0:NW];

  logic signed [67:0]  e2;
  qrs_pkg::sat_t       vs;
  logic [31:0]         mb, mc;

  always_comb begin
    e2 = 68'(m3 >>> FRAC_BITS) + 68'(c3);
    vs = qrs_pkg::sat32(e2);
    mb = b3[31] ? 32'(-b3) : 32'(b3);
    mc = c3[31] ? 32'(-c3) : 32'(c3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (adv) begin
      dv_v[0] <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_sd[0].cmd   <= cmd3;
      dv_sd[0].val   <= vs.q;
      dv_sd[0].esat  <= esat3 || vs.hit;
      dv_sd[0].meets <= meets3;
      dv_sd[0].azero <= (a3 == '0);
      dv_den[0]      <= a3[31] ? 32'(-a3) : 32'(a3);
      dv_nb[0]       <= {mb, {FRAC_BITS{1'b0}}};
      dv_nc[0]       <= {mc, {FRAC_BITS{1'b0}}};
      dv_rb[0]       <= '0;
      dv_rc[0]       <= '0;
      dv_sp[0]       <= b3[31] ^ a3[31];
      dv_sq[0]       <= c3[31] ^ a3[31];
    end
  end

  // restoring divider, one quotient bit per stage for p and q
  for (genvar k = 0; k < NW; k++) begin : g_div
    logic [32:0] rb, rc;
    logic        gb, gc;

    always_comb begin
      rb = {dv_rb[k], dv_nb[k][NW-1]};
      rc = {dv_rc[k], dv_nc[k][NW-1]};
      gb = rb >= {1'b0, dv_den[k]};
      gc = rc >= {1'b0, dv_den[k]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[k+1] <= 1'b0;
      end else if (adv) begin
        dv_v[k+1] <= dv_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_sd[k+1]  <= dv_sd[k];
        dv_den[k+1] <= dv_den[k];
        dv_sp[k+1]  <= dv_sp[k];
        dv_sq[k+1]  <= dv_sq[k];
        dv_rb[k+1]  <= gb ? 32'(rb - {1'b0, dv_den[k]}) : rb[31:0];
        dv_rc[k+1]  <= gc ? 32'(rc - {1'b0, dv_den[k]}) : rc[31:0];
        dv_nb[k+1]  <= {dv_nb[k][NW-2:0], gb};
        dv_nc[k+1]  <= {dv_nc[k][NW-2:0], gc};
      end
    end
  end

  // signed saturation of p, q
  logic                pq_v;
  qrs_pkg::side_t      pq_sd;
  logic signed [31:0]  p_val, q_val;
  logic                p_sat;
  logic                pb_hi, qc_hi, pb_ov, qc_ov;
  logic [NW-1:0]       qb, qcq;

  always_comb begin
    qb    = dv_nb[NW];
    qcq   = dv_nc[NW];
    pb_hi = |qb[NW-1:32];
    qc_hi = |qcq[NW-1:32];
    pb_ov = dv_sp[NW] ? (pb_hi || (qb[31] && |qb[30:0])) : (pb_hi || qb[31]);
    qc_ov = dv_sq[NW] ? (qc_hi || (qcq[31] && |qcq[30:0])) : (qc_hi || qcq[31]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pq_v <= 1'b0;
    end else if (adv) begin
      pq_v <= dv_v[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pq_sd <= dv_sd[NW];
      p_sat <= pb_ov || qc_ov;
      if (pb_ov) begin
        p_val <= dv_sp[NW] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
        p_val <= dv_sp[NW] ? 32'(-qb[31:0]) : qb[31:0];
      end
      if (qc_ov) begin
        q_val <= dv_sq[NW] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
        q_val <= dv_sq[NW] ? 32'(-qcq[31:0]) : qcq[31:0];
      end
    end
  end

  // p*p and 4q scaled
  logic                mq_v;
  qrs_pkg::side_t      mq_sd;
  logic signed [31:0]  mq_p;
  logic                mq_sat;
  logic signed [63:0]  pp, q4;

  always_ff @(posedge clk) begin
    if (rst) begin
      mq_v <= 1'b0;
    end else if (adv) begin
      mq_v <= pq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mq_sd  <= pq_sd;
      mq_p   <= p_val;
      mq_sat <= p_sat;
      pp     <= 64'(p_val) * 64'(p_val);
      q4     <= 64'(q_val) <<< (FRAC_BITS + 2);
    end
  end

  // delta and square root, one root bit per stage
  logic                sq_v    [0:32];
  qrs_pkg::side_t      sq_sd   [0:32];
  logic signed [31:0]  sq_p    [0:32];
  logic                sq_sat  [0:32];
  logic                sq_neg  [0:32];
  logic                sq_zero [0:32];
  logic [63:0]         sq_rad  [0:32];
  logic [34:0]         sq_rem  [0:32];
  logic [31:0]         sq_root [0:32];
  logic signed [64:0]  delta;

  assign delta = 65'(pp) - 65'(q4);

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else if (adv) begin
      sq_v[0] <= mq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_sd[0]   <= mq_sd;
      sq_p[0]    <= mq_p;
      sq_sat[0]  <= mq_sat;
      sq_neg[0]  <= delta[64];
      sq_zero[0] <= (delta == '0);
      sq_rad[0]  <= delta[64] ? 64'(-delta) : delta[63:0];
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
    end
  end

  for (genvar j = 0; j < 32; j++) begin : g_sqrt
    logic [36:0] rr, tr;
    logic        ge;

    always_comb begin
      rr = {sq_rem[j], sq_rad[j][63:62]};
      tr = {3'b000, sq_root[j], 2'b01};
      ge = rr >= tr;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[j+1] <= 1'b0;
      end else if (adv) begin
        sq_v[j+1] <= sq_v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_sd[j+1]   <= sq_sd[j];
        sq_p[j+1]    <= sq_p[j];
        sq_sat[j+1]  <= sq_sat[j];
        sq_neg[j+1]  <= sq_neg[j];
        sq_zero[j+1] <= sq_zero[j];
        sq_rad[j+1]  <= {sq_rad[j][61:0], 2'b00};
        sq_rem[j+1]  <= ge ? 35'(rr - tr) : rr[34:0];
        sq_root[j+1] <= {sq_root[j][30:0], ge};
      end
    end
  end

  // roots and result select
  logic signed [34:0]  np, sm1, sm2;
  qrs_pkg::sat_t       rs1, rs2, rs0;
  qrs_pkg::side_t      fs;
  logic [30:0]         ht;
  logic signed [31:0]  f_r1, f_r2, f_i1, f_i2, f_val;
  logic [1:0]          f_cnt, f_st;
  logic                f_meets;

  always_comb begin
    fs  = sq_sd[32];
    np  = -35'(sq_p[32]);
    sm1 = np - 35'({1'b0, sq_root[32]});
    sm2 = np + 35'({1'b0, sq_root[32]});
    rs1 = qrs_pkg::sat32(68'(sm1 >>> 1));
    rs2 = qrs_pkg::sat32(68'(sm2 >>> 1));
    rs0 = qrs_pkg::sat32(68'(np >>> 1));
    ht  = sq_root[32][31:1];

    f_r1    = '0;
    f_r2    = '0;
    f_i1    = '0;
    f_i2    = '0;
    f_val   = '0;
    f_cnt   = qrs_pkg::CNT_CPLX;
    f_meets = 1'b0;
    f_st    = qrs_pkg::ST_OK;

    case (fs.cmd)
      qrs_pkg::CMD_SOLVE: begin
        if (fs.azero) begin
          f_st = qrs_pkg::ST_AZERO;
        end else begin
          if (!sq_neg[32] && !sq_zero[32]) begin
            f_r1  = rs1.q;
            f_r2  = rs2.q;
            f_cnt = qrs_pkg::CNT_TWO;
            f_st  = (sq_sat[32] || rs1.hit || rs2.hit) ? qrs_pkg::ST_SAT : qrs_pkg::ST_OK;
          end else begin
            f_r1 = rs0.q;
            f_r2 = rs0.q;
            if (sq_zero[32]) begin
              f_cnt = qrs_pkg::CNT_DOUBLE;
            end else begin
              f_i1 = -32'({1'b0, ht});
              f_i2 = 32'({1'b0, ht});
            end
            f_st = (sq_sat[32] || rs0.hit) ? qrs_pkg::ST_SAT : qrs_pkg::ST_OK;
          end
        end
      end
      qrs_pkg::CMD_EVAL: begin
        f_val = fs.val;
        f_st  = fs.esat ? qrs_pkg::ST_SAT : qrs_pkg::ST_OK;
      end
      qrs_pkg::CMD_MEET: begin
        f_meets = fs.meets;
      end
      default: begin
        f_st = qrs_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= sq_v[32];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      first_real      <= f_r1;
      first_imag      <= f_i1;
      second_real     <= f_r2;
      second_imag     <= f_i2;
      real_root_count <= f_cnt;
      poly_value      <= f_val;
      meets           <= f_meets;
      status          <= f_st;
    end
  end

  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && real_root_count == qrs_pkg::CNT_TWO |-> first_real <= second_real)
    else $error("real roots out of order");

  a_conj: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> first_imag == -second_imag && second_imag >= 0)
    else $error("imaginary parts not conjugate");

  a_azero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == qrs_pkg::ST_AZERO |->
      first_real == 0 && second_real == 0 && real_root_count == qrs_pkg::CNT_CPLX)
    else $error("zero leading coefficient result not cleared");

  a_meets: assert property (@(posedge clk) disable iff (rst)
    out_valid && meets |-> poly_value == 0 && status == qrs_pkg::ST_OK)
    else $error("intersect result mixed with other fields");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(first_real) && $stable(status))
    else $error("stalled result lost");

endmodule
